[hw/rtl/hkie_pkg.sv]
// Package with the types, constants and pattern table of the transliteration encoder.
`timescale 1ns / 1ps

package hkie_pkg;

   localparam int WIN_DEPTH = 3;
   localparam int NUM_RULES = 24;

   typedef logic [7:0] byte_type;

   // One pattern: up to three source characters and up to three UTF-8 bytes.
   typedef struct packed {
      byte_type   p0;
      byte_type   p1;
      byte_type   p2;
      logic [1:0] plen;
      byte_type   u0;
      byte_type   u1;
      byte_type   u2;
      logic [1:0] ulen;
   } rule_type;

   // Outcome of consuming the head of the window.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
      logic [1:0]      drop;
   } match_type;

   // A group of up to three output bytes handed to the output stage.
   typedef struct packed {
      logic            load;
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
      logic            last;
   } grp_type;

   localparam byte_type CHR_LBRACE = 8'h7B;
   localparam byte_type CHR_RBRACE = 8'h7D;

   // Patterns in priority order; the first hit wins.
   localparam rule_type RULES [NUM_RULES] = '{
      '{"A", 8'h00, 8'h00, 2'd1, 8'hC4, 8'h81, 8'h00, 2'd2},
      '{"I", 8'h00, 8'h00, 2'd1, 8'hC4, 8'hAB, 8'h00, 2'd2},
      '{"U", 8'h00, 8'h00, 2'd1, 8'hC5, 8'hAB, 8'h00, 2'd2},
      '{"R", "R",   8'h00, 2'd2, 8'hE1, 8'hB9, 8'h9D, 2'd3},
      '{"R", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'h9B, 2'd3},
      '{"L", "L",   8'h00, 2'd2, 8'hE1, 8'hB8, 8'hB9, 2'd3},
      '{"L", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB8, 8'hB7, 2'd3},
      '{"a", "a",   8'h00, 2'd2, 8'hC4, 8'h81, 8'h00, 2'd2},
      '{"i", "i",   8'h00, 2'd2, 8'hC4, 8'hAB, 8'h00, 2'd2},
      '{"u", "u",   8'h00, 2'd2, 8'hC5, 8'hAB, 8'h00, 2'd2},
      '{".", "r",   "r",   2'd3, 8'hE1, 8'hB9, 8'h9D, 2'd3},
      '{".", "r",   8'h00, 2'd2, 8'hE1, 8'hB9, 8'h9B, 2'd3},
      '{".", "l",   "l",   2'd3, 8'hE1, 8'hB8, 8'hB9, 2'd3},
      '{".", "l",   8'h00, 2'd2, 8'hE1, 8'hB8, 8'hB7, 2'd3},
      '{"M", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'h83, 2'd3},
      '{"H", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB8, 8'hA5, 2'd3},
      '{"G", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'h85, 2'd3},
      '{"J", 8'h00, 8'h00, 2'd1, 8'hC3, 8'hB1, 8'h00, 2'd2},
      '{"T", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'hAD, 2'd3},
      '{"D", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB8, 8'h8D, 2'd3},
      '{"N", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'h87, 2'd3},
      '{"S", 8'h00, 8'h00, 2'd1, 8'hE1, 8'hB9, 8'hA3, 2'd3},
      '{"s", "h",   8'h00, 2'd2, 8'hC5, 8'h9B, 8'h00, 2'd2},
      '{"z", 8'h00, 8'h00, 2'd1, 8'hC5, 8'h9B, 8'h00, 2'd2}
   };

endpackage

[hw/rtl/hkie_if.sv]
// Valid/ready channel interfaces for source characters and UTF-8 result bytes.
`timescale 1ns / 1ps

interface hkie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hkie_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   output ready);
endinterface

[hw/rtl/harvard_kyoto_to_iast_encoder_top.sv]
// Top level of the Harvard-Kyoto to IAST UTF-8 transliteration encoder.
`timescale 1ns / 1ps

// The encoder takes one ASCII character per req beat and sends UTF-8 bytes, one per rsp
// beat, with out_last on the final beat of each string and a lone beat with out_valid 0
// when a string produces no bytes. Characters wait in a three-byte window; a character that
// neither fills the window nor ends the string is taken every cycle outside a flush. A
// character that fills the window is taken only while the single group register is free and
// is converted in that cycle; its up to three UTF-8 bytes leave that register one per cycle
// while the result channel is ready. The last character of a string flushes the window: one
// head is consumed per cycle once the group register is free, so a string end takes up to
// three consume steps and up to nine output beats before the next string starts.

module harvard_kyoto_to_iast_encoder_top import hkie_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hkie_req_if.sink   req_bus,
   hkie_rsp_if.source rsp_bus
);

   grp_type grp;
   logic    grp_free;

   hkie_window u_window (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .grp_free (grp_free),
      .grp      (grp)
   );

   hkie_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .grp      (grp),
      .grp_free (grp_free),
      .rsp      (rsp_bus)
   );

endmodule

[hw/rtl/hkie_match.sv]
// Pattern matcher that consumes the head of the pending window.
`timescale 1ns / 1ps

module hkie_match import hkie_pkg::*; (
   input  logic [2:0][7:0] win,
   input  logic [1:0]      count,
   output match_type       result
);

   logic [NUM_RULES-1:0] hit;
   logic                 any_hit;

   // Each pattern is checked on its own, only over the bytes that are pending.
   always_comb begin
      for (int r = 0; r < NUM_RULES; r++) begin
         hit[r] = (RULES[r].plen <= count) &&
                  (win[0] == RULES[r].p0) &&
                  ((RULES[r].plen < 2'd2) || (win[1] == RULES[r].p1)) &&
                  ((RULES[r].plen < 2'd3) || (win[2] == RULES[r].p2));
      end
   end

   assign any_hit = |hit;

   // The first pattern in table order wins; otherwise drop the separator or pass through.
   always_comb begin
      result       = '0;
      result.bytes = '0;
      if (any_hit) begin
         for (int r = NUM_RULES - 1; r >= 0; r--) begin
            if (hit[r]) begin
               result.bytes[0] = RULES[r].u0;
               result.bytes[1] = RULES[r].u1;
               result.bytes[2] = RULES[r].u2;
               result.len      = RULES[r].ulen;
               result.drop     = RULES[r].plen;
            end
         end
      end else if ((count >= 2'd2) && (win[0] == CHR_LBRACE) && (win[1] == CHR_RBRACE)) begin
         result.len  = 2'd0;
         result.drop = 2'd2;
      end else begin
         result.bytes[0] = win[0];
         result.len      = 2'd1;
         result.drop     = 2'd1;
      end
   end

endmodule

[hw/rtl/hkie_serial.sv]
// Output stage that holds one group of result bytes and sends it a beat at a time.
`timescale 1ns / 1ps

module hkie_serial import hkie_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  grp_type        grp,
   output logic           grp_free,
   hkie_rsp_if.source     rsp
);

   logic            valid_ff, valid_in;
   logic [1:0]      idx_ff, idx_in;
   logic [2:0][7:0] bytes_ff, bytes_in;
   logic [1:0]      len_ff, len_in;
   logic            last_ff, last_in;
   logic            final_beat;
   logic            beat;

   // An empty group is the end marker and goes out as a single beat.
   assign final_beat = (len_ff == 2'd0) || (idx_ff == len_ff - 2'd1);
   assign beat       = valid_ff && rsp.ready;
   assign grp_free   = !valid_ff || (beat && final_beat);

   // Group register and beat index.
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      bytes_in = bytes_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      if (grp.load && grp_free) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         bytes_in = grp.bytes;
         len_in   = grp.len;
         last_in  = grp.last;
      end else if (beat && final_beat) begin
         valid_in = 1'b0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bytes_ff <= bytes_in;
      len_ff   <= len_in;
      last_ff  <= last_in;
   end

   // Result channel drive.
   assign rsp.valid     = valid_ff;
   assign rsp.out_byte  = (len_ff == 2'd0) ? 8'h00 : bytes_ff[idx_ff];
   assign rsp.out_valid = (len_ff != 2'd0);
   assign rsp.out_last  = last_ff && final_beat;

   // The beat index stays inside the group that is being sent.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (len_ff != 2'd0) |-> idx_ff < len_ff)
      else $error("beat index past end of group");

   // A new group is never loaded over one that still has beats to send.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp.ready |=> $stable(bytes_ff) && $stable(len_ff) && valid_ff)
      else $error("group changed while a beat was stalled");

endmodule

[hw/rtl/hkie_window.sv]
// Pending window, flush control and the single consume step per cycle.
`timescale 1ns / 1ps

module hkie_window import hkie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hkie_req_if.sink    req,
   input  logic        grp_free,
   output grp_type     grp
);

   logic [2:0][7:0] win_ff, win_in;
   logic [1:0]      count_ff, count_in;
   logic            flush_ff, flush_in;

   logic [2:0][7:0] win_app;
   logic [1:0]      count_app;
   logic [2:0][7:0] eng_win;
   logic [1:0]      eng_cnt;
   logic [2:0][7:0] rem_win;
   logic [1:0]      rem_cnt;
   logic            accept;
   logic            consume;
   logic            last_mode;
   logic            rem_brace;
   logic            done;
   match_type       mres;

   // A beat that fills the window or ends the string needs the output stage free.
   assign req.ready = !flush_ff &&
                      (grp_free || ((count_ff != 2'd2) && !req.in_last));
   assign accept    = req.valid && req.ready;

   // Window with the incoming character appended.
   always_comb begin
      win_app           = win_ff;
      win_app[count_ff] = req.in_byte;
   end
   assign count_app = count_ff + 2'd1;

   // While flushing, the stored window is consumed; otherwise the appended one.
   assign eng_win   = flush_ff ? win_ff : win_app;
   assign eng_cnt   = flush_ff ? count_ff : count_app;
   assign last_mode = flush_ff || req.in_last;
   assign consume   = flush_ff ? grp_free
                               : (accept && ((count_ff == 2'd2) || req.in_last));

   hkie_match u_match (
      .win    (eng_win),
      .count  (eng_cnt),
      .result (mres)
   );

   // Shift out the consumed bytes.
   always_comb begin
      rem_win = '0;
      unique case (mres.drop)
         2'd1: begin
            rem_win[0] = eng_win[1];
            rem_win[1] = eng_win[2];
         end
         2'd2: begin
            rem_win[0] = eng_win[2];
         end
         default: begin
            rem_win = (mres.drop == 2'd0) ? eng_win : '0;
         end
      endcase
   end
   assign rem_cnt = eng_cnt - mres.drop;

   // A leftover separator pair emits nothing, so the current group already ends the string.
   assign rem_brace = (rem_cnt == 2'd2) && (rem_win[0] == CHR_LBRACE) &&
                      (rem_win[1] == CHR_RBRACE);
   assign done      = last_mode && ((rem_cnt == 2'd0) || rem_brace);

   // Group handed to the output stage; an empty final group is the end marker.
   always_comb begin
      grp       = '0;
      grp.load  = consume && ((mres.len != 2'd0) || done);
      grp.bytes = mres.bytes;
      grp.len   = mres.len;
      grp.last  = done;
   end

   // Window state update.
   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      if (consume) begin
         win_in   = done ? '0 : rem_win;
         count_in = done ? 2'd0 : rem_cnt;
         flush_in = last_mode && !done;
      end else if (accept) begin
         win_in   = win_app;
         count_in = count_app;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         count_ff <= 2'd0;
         flush_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         count_ff <= count_in;
         flush_ff <= flush_in;
      end
   end

   // Outside a flush the window never rests full.
   a_not_full: assert property (@(posedge clock) disable iff (reset)
      !flush_ff |-> count_ff != 2'd3)
      else $error("window left full outside a flush");

   // A flush only runs while bytes are pending.
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> count_ff != 2'd0)
      else $error("flush with empty window");

   // Consuming always removes at least one pending byte.
   a_drop_nonzero: assert property (@(posedge clock) disable iff (reset)
      consume |-> (mres.drop != 2'd0) && (mres.drop <= eng_cnt))
      else $error("consume step dropped no byte or too many");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the Harvard-Kyoto to IAST UTF-8 transliteration encoder.
`timescale 1ns / 1ps

module tb_top;

   localparam int WIN          = 3;
   localparam int TABLE_SIZE   = 24;
   localparam int TARGET_CHARS = 470;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   localparam logic [7:0] LBRACE = 8'h7B;
   localparam logic [7:0] RBRACE = 8'h7D;

   // One transliteration entry: source pattern head first, UTF-8 bytes first byte first.
   typedef struct packed {
      logic [23:0] pat;
      logic [1:0]  plen;
      logic [23:0] utf;
      logic [1:0]  ulen;
   } hk_entry_type;

   // One source character as it is sent on the request channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } hk_char_type;

   // One UTF-8 output beat as it should appear on the result channel.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } utf_beat_type;

   // Entries in priority order; the first one that fits the window head wins.
   localparam hk_entry_type HK_TABLE [TABLE_SIZE] = '{
      '{{"A", 8'h00, 8'h00}, 2'd1, 24'hC48100, 2'd2},
      '{{"I", 8'h00, 8'h00}, 2'd1, 24'hC4AB00, 2'd2},
      '{{"U", 8'h00, 8'h00}, 2'd1, 24'hC5AB00, 2'd2},
      '{{"R", "R",   8'h00}, 2'd2, 24'hE1B99D, 2'd3},
      '{{"R", 8'h00, 8'h00}, 2'd1, 24'hE1B99B, 2'd3},
      '{{"L", "L",   8'h00}, 2'd2, 24'hE1B8B9, 2'd3},
      '{{"L", 8'h00, 8'h00}, 2'd1, 24'hE1B8B7, 2'd3},
      '{{"a", "a",   8'h00}, 2'd2, 24'hC48100, 2'd2},
      '{{"i", "i",   8'h00}, 2'd2, 24'hC4AB00, 2'd2},
      '{{"u", "u",   8'h00}, 2'd2, 24'hC5AB00, 2'd2},
      '{{".", "r",   "r"  }, 2'd3, 24'hE1B99D, 2'd3},
      '{{".", "r",   8'h00}, 2'd2, 24'hE1B99B, 2'd3},
      '{{".", "l",   "l"  }, 2'd3, 24'hE1B8B9, 2'd3},
      '{{".", "l",   8'h00}, 2'd2, 24'hE1B8B7, 2'd3},
      '{{"M", 8'h00, 8'h00}, 2'd1, 24'hE1B983, 2'd3},
      '{{"H", 8'h00, 8'h00}, 2'd1, 24'hE1B8A5, 2'd3},
      '{{"G", 8'h00, 8'h00}, 2'd1, 24'hE1B985, 2'd3},
      '{{"J", 8'h00, 8'h00}, 2'd1, 24'hC3B100, 2'd2},
      '{{"T", 8'h00, 8'h00}, 2'd1, 24'hE1B9AD, 2'd3},
      '{{"D", 8'h00, 8'h00}, 2'd1, 24'hE1B88D, 2'd3},
      '{{"N", 8'h00, 8'h00}, 2'd1, 24'hE1B987, 2'd3},
      '{{"S", 8'h00, 8'h00}, 2'd1, 24'hE1B9A3, 2'd3},
      '{{"s", "h",   8'h00}, 2'd2, 24'hC59B00, 2'd2},
      '{{"z", 8'h00, 8'h00}, 2'd1, 24'hC59B00, 2'd2}
   };

   // Source fragments used to build random text that exercises the table.
   string hk_tokens [25] = '{"A", "I", "U", "RR", "R", "LL", "L", "aa", "ii", "uu",
                             ".rr", ".r", ".ll", ".l", "M", "H", "G", "J", "T", "D",
                             "N", "S", "sh", "z", "{}"};
   string broken_pieces = "{}.sRL";

   logic clock;
   logic reset;

   hkie_req_if req_bus ();
   hkie_rsp_if rsp_bus ();

   harvard_kyoto_to_iast_encoder_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hk_char_type  hk_text [$];
   utf_beat_type utf_expected [$];
   hk_char_type  next_char;

   // Predictor state: pending source bytes, head first.
   logic [7:0] win [WIN] = '{default: 8'h00};
   int         win_cnt = 0;
   logic [7:0] step_bytes [$];

   int total_chars    = 0;
   int accepted_chars = 0;
   int fail_count     = 0;
   int cycle_count    = 0;
   int req_gap        = 0;
   int rsp_stall      = 0;
   bit req_calm       = 0;
   bit rsp_calm       = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Shift the window left by k bytes, filling the tail with zero.
   function automatic void drop_window_head(int k);
      for (int i = 0; i < WIN; i++) begin
         win[i] = (i + k < win_cnt) ? win[i + k] : 8'h00;
      end
      win_cnt = (k > win_cnt) ? 0 : win_cnt - k;
   endfunction

   // True when every byte of the entry's pattern sits at the window head.
   function automatic bit head_matches(hk_entry_type e);
      if (e.plen > win_cnt) return 1'b0;
      for (int j = 0; j < e.plen; j++) begin
         if (win[j] != e.pat[23 - 8 * j -: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Consume the window head: table entry, separator drop, or plain pass-through.
   function automatic void consume_window_head();
      hk_entry_type e;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         e = HK_TABLE[i];
         if (head_matches(e)) begin
            for (int j = 0; j < e.ulen; j++) step_bytes.push_back(e.utf[23 - 8 * j -: 8]);
            drop_window_head(e.plen);
            return;
         end
      end
      if (win_cnt >= 2 && win[0] == LBRACE && win[1] == RBRACE) begin
         drop_window_head(2);
         return;
      end
      step_bytes.push_back(win[0]);
      drop_window_head(1);
   endfunction

   // Work out the UTF-8 beats that one accepted source character causes.
   function automatic void transliterate_char(logic [7:0] ch, logic last);
      utf_beat_type beat;
      step_bytes.delete();
      if (win_cnt >= WIN) consume_window_head();
      win[win_cnt] = ch;
      win_cnt++;
      if (!last) begin
         while (win_cnt >= WIN) consume_window_head();
      end else begin
         while (win_cnt > 0) consume_window_head();
      end
      // A string end with nothing to send still closes with an empty marker beat.
      if (last && step_bytes.size() == 0) begin
         beat = '{data: 8'h00, valid: 1'b0, last: 1'b1};
         utf_expected.push_back(beat);
      end
      foreach (step_bytes[i]) begin
         beat = '{data: step_bytes[i], valid: 1'b1,
                  last: last && (i == step_bytes.size() - 1)};
         utf_expected.push_back(beat);
      end
   endfunction

   // Queue one string of source characters, last mark on its final character.
   task automatic queue_string(input logic [7:0] chars [$]);
      hk_char_type c;
      foreach (chars[i]) begin
         c = '{ch: chars[i], last: (i == chars.size() - 1)};
         hk_text.push_back(c);
      end
   endtask

   task automatic queue_text(input string s);
      logic [7:0] chars [$];
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      queue_string(chars);
   endtask

   // Request driver: presents queued characters with random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'h00;
         req_bus.in_last <= 1'b0;
         req_gap         <= 0;
      end else begin
         if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= req_gap - 1;
            end else if (hk_text.size() > 0) begin
               next_char        = hk_text.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.in_byte <= next_char.ch;
               req_bus.in_last <= next_char.last;
               req_gap         <= req_calm ? 0 : idle_len();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result back-pressure: random stalls, with calm stretches of none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else begin
         if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall     <= rsp_stall - 1;
         end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall     <= idle_len();
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted character, then check each accepted result beat.
   always @(posedge clock) begin
      utf_beat_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            transliterate_char(req_bus.in_byte, req_bus.in_last);
            accepted_chars++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (utf_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected beat: byte %02h valid %0d last %0d",
                           rsp_bus.out_byte, rsp_bus.out_valid, rsp_bus.out_last);
            end else begin
               want = utf_expected.pop_front();
               if (rsp_bus.out_byte !== want.data || rsp_bus.out_valid !== want.valid ||
                   rsp_bus.out_last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display({"mismatch: expected byte %02h valid %0d last %0d, ",
                               "got byte %02h valid %0d last %0d"},
                              want.data, want.valid, want.last, rsp_bus.out_byte,
                              rsp_bus.out_valid, rsp_bus.out_last);
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stimulus, reset and end of test.
   initial begin
      logic [7:0] chars [$];
      string      tok;
      int         text_len;
      int         pick;

      reset = 1'b1;

      // Directed strings: lone R at the end, empty marker, widest flush, longest patterns,
      // separator splitting a pair, and the byte extremes.
      queue_text("R");
      queue_text("{}");
      queue_text("MSN");
      queue_text(".rr");
      queue_text("LLz");
      queue_text("sh");
      queue_text("a{}a");
      queue_text(".l");
      chars = '{8'h01, 8'hFF, "J"};
      queue_string(chars);

      // Random strings, mostly built from table patterns, with noise and broken pieces.
      while (hk_text.size() < TARGET_CHARS) begin
         text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
         chars.delete();
         while (chars.size() < text_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               tok = hk_tokens[$urandom_range(0, 24)];
               for (int i = 0; i < tok.len(); i++) chars.push_back(tok[i]);
            end else if (pick < 85) begin
               chars.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 95) begin
               chars.push_back(8'($urandom_range(1, 255)));
            end else begin
               chars.push_back(broken_pieces[$urandom_range(0, broken_pieces.len() - 1)]);
            end
         end
         queue_string(chars);
      end
      total_chars = hk_text.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every character to be taken and every predicted beat to arrive.
      while (accepted_chars < total_chars || utf_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      fail_count += utf_expected.size();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
